>>> design/e2c_pkg.sv
// ----------------------------------------------------------------------------
// e2c_pkg: shared types and constants for the epoch to calendar converter
// Holds the time constants, the day-split reciprocal, the leap-year phase
// seeds, the hand-off record between the front and back parts, the state
// types and the month table.
// ----------------------------------------------------------------------------
package e2c_pkg;

    // Width of the incoming seconds count and of the split results.
    localparam int unsigned SECS_W = 32;
    localparam int unsigned DAYS_W = 16;   // at most 49710 whole days
    localparam int unsigned TOD_W  = 17;   // seconds of day, below 86400

    // Time constants.
    localparam logic [TOD_W:0]   DAY_SECS  = 18'd86400;
    localparam logic [TOD_W-1:0] HOUR_SECS = 17'd3600;
    localparam logic [TOD_W-1:0] MIN_SECS  = 17'd60;

    // Day split by reciprocal multiplication. 86400 is 675 shifted left by 7,
    // so days = ((secs >> 7) * DAY_RECIP) >> 35, where DAY_RECIP rounds 2^35 / 675
    // up. The rounding error stays below one for every 25-bit shifted count.
    localparam int unsigned      DAY_PRE_SHIFT = 7;
    localparam int unsigned      RECIP_W       = 26;
    localparam int unsigned      RECIP_SHIFT   = 35;
    localparam int unsigned      PROD_W        = SECS_W - DAY_PRE_SHIFT + RECIP_W;
    localparam logic [RECIP_W-1:0] DAY_RECIP   = 26'd50903317;

    // Calendar constants.
    localparam logic [11:0]       EPOCH_YEAR  = 12'd1970;
    localparam logic [DAYS_W-1:0] YEAR_COMMON = 16'd365;
    localparam logic [DAYS_W-1:0] YEAR_LEAP   = 16'd366;

    // Phase of the epoch year within the 4, 100 and 400 year cycles.
    localparam logic [1:0] EPOCH_MOD4   = 2'd2;
    localparam logic [6:0] EPOCH_MOD100 = 7'd70;
    localparam logic [8:0] EPOCH_MOD400 = 9'd370;
    localparam logic [6:0] LAST_MOD100  = 7'd99;
    localparam logic [8:0] LAST_MOD400  = 9'd399;

    // Index of December, where the month walk stops.
    localparam logic [3:0] LAST_MONTH = 4'd11;

    // Day count and time of day handed from the front to the back.
    typedef struct packed {
        logic [DAYS_W-1:0] days;
        logic [TOD_W-1:0]  tod;
    } span_t;

    // Front part states.
    typedef enum logic [1:0] {
        FS_IDLE,
        FS_DIV,
        FS_REM,
        FS_PUSH
    } front_state_t;

    // Back part date walk states.
    typedef enum logic [1:0] {
        BS_IDLE,
        BS_YEAR,
        BS_MONTH,
        BS_WAIT
    } back_state_t;

    // Back part time-of-day split states.
    typedef enum logic [1:0] {
        TS_HOUR,
        TS_MIN,
        TS_DONE
    } time_state_t;

    // Length of a month, indexed from zero for January.
    function automatic logic [4:0] month_len(input logic [3:0] mo, input logic leap);
        logic [4:0] len;
        begin
            case (mo)
                4'd1:    len = leap ? 5'd29 : 5'd28;
                4'd3:    len = 5'd30;
                4'd5:    len = 5'd30;
                4'd8:    len = 5'd30;
                4'd10:   len = 5'd30;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

>>> design/epoch_to_calendar.sv
// ----------------------------------------------------------------------------
// epoch_to_calendar: seconds since 1970 to Gregorian date and time of day
// Top level joining the split front, the hand-off queue and the walk back.
// ----------------------------------------------------------------------------
// Usage:
// Drive epoch_seconds and raise start while busy is low; the count is taken
// at that clock edge. busy then stays high while the front splits the count
// into whole days (a reciprocal multiply by 1/86400) and seconds of day and
// hands both to a two-entry queue; it stays high longer only while that queue
// is full. The back walks the years from 1970 (one per cycle) and the months
// (one per cycle), while hours and minutes are peeled off the seconds of day
// by repeated subtraction in parallel. The result appears on year, month,
// day_of_month, hour, minute and second for exactly one cycle with done high,
// once both the date walk and the time split have finished; the year walk
// sets when that is late in the range, the time split early in it. The front
// can take a new count while the back is still walking, until the queue
// fills, and then at the pace of the back. Results leave in the order their
// counts were taken. The receiver cannot stall the block. Reset empties the
// queue and returns both parts to idle.
// ----------------------------------------------------------------------------
module epoch_to_calendar (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] epoch_seconds,
    output logic        busy,
    output logic        done,
    output logic [11:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day_of_month,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second
);

    logic           push;
    logic           full;
    logic           pop;
    logic           empty;
    e2c_pkg::span_t push_data;
    e2c_pkg::span_t pop_data;

    // Front: day and time-of-day split.
    e2c_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .epoch_seconds (epoch_seconds),
        .busy          (busy),
        .push          (push),
        .push_data     (push_data),
        .full          (full)
    );

    // Hand-off queue.
    e2c_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    // Back: calendar walk and result register.
    e2c_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .pop_data     (pop_data),
        .pop          (pop),
        .done         (done),
        .year         (year),
        .month        (month),
        .day_of_month (day_of_month),
        .hour         (hour),
        .minute       (minute),
        .second       (second)
    );

endmodule

>>> design/e2c_front.sv
// ----------------------------------------------------------------------------
// e2c_front: accepts a seconds count and splits it into days and time of day
// A reciprocal multiply gives the whole-day count in the divide state, a
// multiply back and subtract gives the seconds of day in the remainder
// state, and both are pushed into the hand-off queue once it has room.
// ----------------------------------------------------------------------------
module e2c_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [e2c_pkg::SECS_W-1:0] epoch_seconds,
    output logic                       busy,
    output logic                       push,
    output e2c_pkg::span_t             push_data,
    input  logic                       full
);

    e2c_pkg::front_state_t state_reg, state_next;
    logic [e2c_pkg::SECS_W-1:0]        dividend_reg, dividend_next;
    logic [e2c_pkg::TOD_W-1:0]         rem_reg, rem_next;
    logic [e2c_pkg::DAYS_W-1:0]        quo_reg, quo_next;
    logic [e2c_pkg::PROD_W-1:0]        prod;
    logic [e2c_pkg::DAYS_W+e2c_pkg::TOD_W:0] day_base;
    logic [e2c_pkg::SECS_W-1:0]        tod_full;

    // Day count by reciprocal, then seconds of day from the count.
    always_comb
    begin
        prod     = dividend_reg[e2c_pkg::SECS_W-1:e2c_pkg::DAY_PRE_SHIFT] *
                   e2c_pkg::DAY_RECIP;
        day_base = quo_reg * e2c_pkg::DAY_SECS;
        tod_full = dividend_reg - day_base[e2c_pkg::SECS_W-1:0];
    end

    // Next state and datapath control.
    always_comb
    begin
        state_next    = state_reg;
        dividend_next = dividend_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        push          = 1'b0;
        case (state_reg)
            e2c_pkg::FS_IDLE:
            begin
                if (start)
                begin
                    dividend_next = epoch_seconds;
                    state_next    = e2c_pkg::FS_DIV;
                end
            end
            e2c_pkg::FS_DIV:
            begin
                quo_next   = prod[e2c_pkg::PROD_W-1:e2c_pkg::RECIP_SHIFT];
                state_next = e2c_pkg::FS_REM;
            end
            e2c_pkg::FS_REM:
            begin
                // The remainder is below 86400, so the upper bits are zero.
                rem_next   = tod_full[e2c_pkg::TOD_W-1:0];
                state_next = e2c_pkg::FS_PUSH;
            end
            e2c_pkg::FS_PUSH:
            begin
                if (!full)
                begin
                    push       = 1'b1;
                    state_next = e2c_pkg::FS_IDLE;
                end
            end
            default:
            begin
                state_next = e2c_pkg::FS_IDLE;
            end
        endcase
    end

    assign busy           = (state_reg != e2c_pkg::FS_IDLE);
    assign push_data.days = quo_reg;
    assign push_data.tod  = rem_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= e2c_pkg::FS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Split datapath.
    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
    end

endmodule

>>> design/e2c_queue.sv
// ----------------------------------------------------------------------------
// e2c_queue: two-entry queue between the front and back parts
// Holds split day counts so the divider can start on the next count while
// the calendar walk is still running.
// ----------------------------------------------------------------------------
module e2c_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  e2c_pkg::span_t      push_data,
    output logic                full,
    input  logic                pop,
    output e2c_pkg::span_t      pop_data,
    output logic                empty
);

    e2c_pkg::span_t mem_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> design/e2c_back.sv
// ----------------------------------------------------------------------------
// e2c_back: walks years and months and splits the time of day
// The date walk subtracts one year or one month per cycle; the time of day
// is split into hours and minutes by repeated subtraction alongside it.
// ----------------------------------------------------------------------------
module e2c_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                empty,
    input  e2c_pkg::span_t      pop_data,
    output logic                pop,
    output logic                done,
    output logic [11:0]         year,
    output logic [3:0]          month,
    output logic [4:0]          day_of_month,
    output logic [4:0]          hour,
    output logic [5:0]          minute,
    output logic [5:0]          second
);

    e2c_pkg::back_state_t       state_reg, state_next;
    e2c_pkg::time_state_t       tstate_reg, tstate_next;
    logic [e2c_pkg::DAYS_W-1:0] days_reg, days_next;
    logic [e2c_pkg::TOD_W-1:0]  tod_reg, tod_next;
    logic [11:0]                yr_reg, yr_next;
    logic [1:0]                 y4_reg, y4_next;
    logic [6:0]                 y100_reg, y100_next;
    logic [8:0]                 y400_reg, y400_next;
    logic [3:0]                 mo_reg, mo_next;
    logic                       leap_reg, leap_next;
    logic [4:0]                 hr_reg, hr_next;
    logic [5:0]                 mn_reg, mn_next;
    logic                       done_reg, done_next;
    logic [11:0]                year_reg, year_next;
    logic [3:0]                 month_reg, month_next;
    logic [4:0]                 mday_reg, mday_next;
    logic [4:0]                 hour_reg, hour_next;
    logic [5:0]                 minute_reg, minute_next;
    logic [5:0]                 second_reg, second_next;
    logic                       yr_leap;
    logic [e2c_pkg::DAYS_W-1:0] ylen;
    logic [4:0]                 mlen;

    // Leap test from the year's phase counters.
    always_comb
    begin
        yr_leap = ((y4_reg == 2'd0) && (y100_reg != 7'd0)) || (y400_reg == 9'd0);
        ylen    = yr_leap ? e2c_pkg::YEAR_LEAP : e2c_pkg::YEAR_COMMON;
        mlen    = e2c_pkg::month_len(mo_reg, leap_reg);
    end

    // Date walk and result register.
    always_comb
    begin
        state_next  = state_reg;
        days_next   = days_reg;
        yr_next     = yr_reg;
        y4_next     = y4_reg;
        y100_next   = y100_reg;
        y400_next   = y400_reg;
        mo_next     = mo_reg;
        leap_next   = leap_reg;
        done_next   = 1'b0;
        year_next   = year_reg;
        month_next  = month_reg;
        mday_next   = mday_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        pop         = 1'b0;
        case (state_reg)
            e2c_pkg::BS_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    days_next  = pop_data.days;
                    yr_next    = e2c_pkg::EPOCH_YEAR;
                    y4_next    = e2c_pkg::EPOCH_MOD4;
                    y100_next  = e2c_pkg::EPOCH_MOD100;
                    y400_next  = e2c_pkg::EPOCH_MOD400;
                    state_next = e2c_pkg::BS_YEAR;
                end
            end
            e2c_pkg::BS_YEAR:
            begin
                if (days_reg < ylen)
                begin
                    mo_next    = '0;
                    leap_next  = yr_leap;
                    state_next = e2c_pkg::BS_MONTH;
                end
                else
                begin
                    days_next = days_reg - ylen;
                    yr_next   = yr_reg + 12'd1;
                    y4_next   = y4_reg + 2'd1;
                    y100_next = (y100_reg == e2c_pkg::LAST_MOD100) ? 7'd0 : y100_reg + 7'd1;
                    y400_next = (y400_reg == e2c_pkg::LAST_MOD400) ? 9'd0 : y400_reg + 9'd1;
                end
            end
            e2c_pkg::BS_MONTH:
            begin
                if ((mo_reg < e2c_pkg::LAST_MONTH) &&
                    (days_reg >= {{(e2c_pkg::DAYS_W-5){1'b0}}, mlen}))
                begin
                    days_next = days_reg - {{(e2c_pkg::DAYS_W-5){1'b0}}, mlen};
                    mo_next   = mo_reg + 4'd1;
                end
                else
                begin
                    state_next = e2c_pkg::BS_WAIT;
                end
            end
            e2c_pkg::BS_WAIT:
            begin
                // Publish once the time-of-day split has also finished.
                if (tstate_reg == e2c_pkg::TS_DONE)
                begin
                    done_next   = 1'b1;
                    year_next   = yr_reg;
                    month_next  = mo_reg + 4'd1;
                    mday_next   = 5'(days_reg + 16'd1);
                    hour_next   = hr_reg;
                    minute_next = mn_reg;
                    second_next = tod_reg[5:0];
                    state_next  = e2c_pkg::BS_IDLE;
                end
            end
            default:
            begin
                state_next = e2c_pkg::BS_IDLE;
            end
        endcase
    end

    // Time-of-day split, started by the same queue transfer.
    always_comb
    begin
        tstate_next = tstate_reg;
        tod_next    = tod_reg;
        hr_next     = hr_reg;
        mn_next     = mn_reg;
        if (pop)
        begin
            tod_next    = pop_data.tod;
            hr_next     = '0;
            mn_next     = '0;
            tstate_next = e2c_pkg::TS_HOUR;
        end
        else
        begin
            case (tstate_reg)
                e2c_pkg::TS_HOUR:
                begin
                    if (tod_reg >= e2c_pkg::HOUR_SECS)
                    begin
                        tod_next = tod_reg - e2c_pkg::HOUR_SECS;
                        hr_next  = hr_reg + 5'd1;
                    end
                    else
                    begin
                        tstate_next = e2c_pkg::TS_MIN;
                    end
                end
                e2c_pkg::TS_MIN:
                begin
                    if (tod_reg >= e2c_pkg::MIN_SECS)
                    begin
                        tod_next = tod_reg - e2c_pkg::MIN_SECS;
                        mn_next  = mn_reg + 6'd1;
                    end
                    else
                    begin
                        tstate_next = e2c_pkg::TS_DONE;
                    end
                end
                e2c_pkg::TS_DONE:
                begin
                    tstate_next = e2c_pkg::TS_DONE;
                end
                default:
                begin
                    tstate_next = e2c_pkg::TS_DONE;
                end
            endcase
        end
    end

    assign done         = done_reg;
    assign year         = year_reg;
    assign month        = month_reg;
    assign day_of_month = mday_reg;
    assign hour         = hour_reg;
    assign minute       = minute_reg;
    assign second       = second_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= e2c_pkg::BS_IDLE;
            tstate_reg <= e2c_pkg::TS_DONE;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            tstate_reg <= tstate_next;
            done_reg   <= done_next;
        end
    end

    // Walk datapath and result registers.
    always_ff @(posedge clk)
    begin
        days_reg   <= days_next;
        tod_reg    <= tod_next;
        yr_reg     <= yr_next;
        y4_reg     <= y4_next;
        y100_reg   <= y100_next;
        y400_reg   <= y400_next;
        mo_reg     <= mo_next;
        leap_reg   <= leap_next;
        hr_reg     <= hr_next;
        mn_reg     <= mn_next;
        year_reg   <= year_next;
        month_reg  <= month_next;
        mday_reg   <= mday_next;
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
        second_reg <= second_next;
    end

endmodule

>>> design/e2c_checker.sv
// ----------------------------------------------------------------------------
// e2c_checker: port-level checks for the epoch to calendar converter
// Watches the command and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
module e2c_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        done,
    input  logic [11:0] year,
    input  logic [3:0]  month,
    input  logic [4:0]  day_of_month,
    input  logic [4:0]  hour,
    input  logic [5:0]  minute,
    input  logic [5:0]  second
);

    // A taken command keeps the block busy while it divides.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after a command transfer");

    // Results are single-cycle pulses, never back to back.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // A result transfer carries a date inside the 32-bit range.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (year >= 12'd1970) && (year <= 12'd2106) &&
                 (month >= 4'd1) && (month <= 4'd12) &&
                 (day_of_month >= 5'd1))
        else $error("date out of range on a result transfer");

    // A result transfer carries a valid time of day.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd59))
        else $error("time of day out of range on a result transfer");

endmodule

bind epoch_to_calendar e2c_checker u_e2c_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .hour         (hour),
    .minute       (minute),
    .second       (second)
);
